// ===== rtl/two_body_decay_kinematics_defines.svh =====
// ----------------------------------------------------------------------------
// Decay kinematics assertion macros
// Assertion macros shared by the RTL files of the decay kinematics block.
// ----------------------------------------------------------------------------
`ifndef TWO_BODY_DECAY_KINEMATICS_DEFINES_SVH
`define TWO_BODY_DECAY_KINEMATICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define TBDK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is applied.
`define TBDK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/tbdk_pkg.sv =====
// ----------------------------------------------------------------------------
// tbdk_pkg
// Shared widths, latencies, register indexes and types of the two-body decay
// kinematics pipeline.
// ----------------------------------------------------------------------------
package tbdk_pkg;

  localparam int MASS_W   = 16;
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 15;
  localparam int MOM_W    = 17;
  localparam int SQ_W     = 34;          // |W^2 - (m1+m2)^2| and the root
  localparam int HALF_W   = SQ_W / 2;
  localparam int RAD_W    = 2 * SQ_W;    // radicand width
  localparam int REM_W    = SQ_W + 1;    // square root remainder
  localparam int DVS_W    = MASS_W + 1;  // divisor 2W
  localparam int NUM_W    = SQ_W;        // divider numerator
  localparam int SQRT_LAT = SQ_W;
  localparam int DIV_LAT  = MASS_W + 1;
  localparam int FRONT_LAT = 5;
  localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + 2;

  localparam int NREG    = 7;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROTON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NPION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_N   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_PI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_W   = 3'd6;

  localparam logic [MASS_W-1:0] CFG_RESET [NREG] =
    '{16'd15012, 16'd15033, 16'd2233, 16'd2160, 16'd15023, 16'd2209, 16'd17280};

  // Mass registers as seen by the front end.
  typedef struct packed {
    logic [MASS_W-1:0] proton;
    logic [MASS_W-1:0] neutron;
    logic [MASS_W-1:0] cpion;
    logic [MASS_W-1:0] npion;
    logic [MASS_W-1:0] avg_n;
    logic [MASS_W-1:0] avg_pi;
    logic [MASS_W-1:0] min_w;
  } mass_t;

  // Per-item control and payload that travels beside the arithmetic.
  typedef struct packed {
    logic                    valid;
    logic                    below;
    logic                    wzero;
    logic                    neg;
    logic [NUM_W-1:0]        en_num;
    logic [NUM_W-1:0]        ep_num;
    logic [DVS_W-1:0]        dvs;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } side_t;

endpackage

// ===== rtl/tbdk_front.sv =====
// ----------------------------------------------------------------------------
// tbdk_front
// Mass selection, squares, Kallen factors, energy numerators and the
// split radicand products; five register stages.
// ----------------------------------------------------------------------------
module tbdk_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  tbdk_pkg::mass_t                   mass_i,
  input  logic [tbdk_pkg::MASS_W-1:0]       invariant_mass_i,
  input  logic                              is_neutron_i,
  input  logic                              is_neutral_pion_i,
  input  logic signed [tbdk_pkg::DIR_W-1:0] dir_x_i,
  input  logic signed [tbdk_pkg::DIR_W-1:0] dir_y_i,
  input  logic signed [tbdk_pkg::DIR_W-1:0] dir_z_i,
  output tbdk_pkg::side_t                   side_o,
  output logic [tbdk_pkg::RAD_W-1:0]        rad_o,
  output logic [tbdk_pkg::RAD_W-1:0]        rad_av_o
);

  localparam int MW = tbdk_pkg::MASS_W;
  localparam int SW = tbdk_pkg::SQ_W;
  localparam int HW = tbdk_pkg::HALF_W;

  // Stage 1: register the item and select the masses.
  logic            v1_q, v1_d;
  logic [MW-1:0]   w1_q, mn1_q, mp1_q, an1_q, ap1_q;
  logic            below1_q;
  logic signed [tbdk_pkg::DIR_W-1:0] dx1_q, dy1_q, dz1_q;

  assign v1_d = in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q     <= invariant_mass_i;
    mn1_q    <= is_neutron_i ? mass_i.neutron : mass_i.proton;
    mp1_q    <= is_neutral_pion_i ? mass_i.npion : mass_i.cpion;
    an1_q    <= mass_i.avg_n;
    ap1_q    <= mass_i.avg_pi;
    below1_q <= invariant_mass_i < mass_i.min_w;
    dx1_q    <= dir_x_i;
    dy1_q    <= dir_y_i;
    dz1_q    <= dir_z_i;
  end

  // Stage 2: squares of W, of each mass, and of mass sums and differences.
  logic [MW:0] s_sel, d_sel, s_av, d_av;
  assign s_sel = {1'b0, mn1_q} + {1'b0, mp1_q};
  assign d_sel = (mn1_q > mp1_q) ? {1'b0, mn1_q - mp1_q} : {1'b0, mp1_q - mn1_q};
  assign s_av  = {1'b0, an1_q} + {1'b0, ap1_q};
  assign d_av  = (an1_q > ap1_q) ? {1'b0, an1_q - ap1_q} : {1'b0, ap1_q - an1_q};

  logic            v2_q;
  logic [MW-1:0]   w2w_q;
  logic            below2_q;
  logic [2*MW-1:0] wsq2_q, mnsq2_q, mpsq2_q;
  logic [SW-1:0]   ssq2_q, dsq2_q, sasq2_q, dasq2_q;
  logic signed [tbdk_pkg::DIR_W-1:0] dx2_q, dy2_q, dz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w2w_q    <= w1_q;
    below2_q <= below1_q;
    wsq2_q   <= w1_q * w1_q;
    mnsq2_q  <= mn1_q * mn1_q;
    mpsq2_q  <= mp1_q * mp1_q;
    ssq2_q   <= SW'(s_sel) * SW'(s_sel);
    dsq2_q   <= SW'(d_sel) * SW'(d_sel);
    sasq2_q  <= SW'(s_av) * SW'(s_av);
    dasq2_q  <= SW'(d_av) * SW'(d_av);
    dx2_q    <= dx1_q;
    dy2_q    <= dy1_q;
    dz2_q    <= dz1_q;
  end

  // Stage 3: Kallen factors, sign test and energy numerators.
  localparam int AW = SW + 2;
  logic signed [AW-1:0] a_sel, b_sel, a_av, b_av, en_s, ep_s;
  logic                 neg_sel, neg_av;
  logic [SW-1:0]        ua_sel, ub_sel, ua_av, ub_av;

  always_comb begin
    a_sel = $signed(AW'(wsq2_q)) - $signed(AW'(ssq2_q));
    b_sel = $signed(AW'(wsq2_q)) - $signed(AW'(dsq2_q));
    a_av  = $signed(AW'(wsq2_q)) - $signed(AW'(sasq2_q));
    b_av  = $signed(AW'(wsq2_q)) - $signed(AW'(dasq2_q));
    neg_sel = a_sel[AW-1] && !b_sel[AW-1] && (b_sel != '0);
    neg_av  = a_av[AW-1] && !b_av[AW-1] && (b_av != '0);
    ua_sel = neg_sel ? '0 : SW'(a_sel[AW-1] ? -a_sel : a_sel);
    ub_sel = neg_sel ? '0 : SW'(b_sel[AW-1] ? -b_sel : b_sel);
    ua_av  = neg_av ? '0 : SW'(a_av[AW-1] ? -a_av : a_av);
    ub_av  = neg_av ? '0 : SW'(b_av[AW-1] ? -b_av : b_av);
    en_s = $signed(AW'(wsq2_q)) + $signed(AW'(mnsq2_q)) - $signed(AW'(mpsq2_q));
    ep_s = $signed(AW'(wsq2_q)) + $signed(AW'(mpsq2_q)) - $signed(AW'(mnsq2_q));
  end

  tbdk_pkg::side_t side3_q, side4_q, side5_q;
  logic            v3_q, v4_q, v5_q;
  logic [SW-1:0]   ua3_q, ub3_q, uaa3_q, uba3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q.valid  <= 1'b0;
    side3_q.below  <= below2_q;
    side3_q.wzero  <= (w2w_q == '0);
    side3_q.neg    <= neg_sel;
    side3_q.en_num <= (en_s[AW-1] || en_s == '0) ? '0 : tbdk_pkg::NUM_W'(en_s);
    side3_q.ep_num <= (ep_s[AW-1] || ep_s == '0) ? '0 : tbdk_pkg::NUM_W'(ep_s);
    side3_q.dvs    <= {w2w_q, 1'b0};
    side3_q.dir_x  <= dx2_q;
    side3_q.dir_y  <= dy2_q;
    side3_q.dir_z  <= dz2_q;
    ua3_q  <= ua_sel;
    ub3_q  <= ub_sel;
    uaa3_q <= ua_av;
    uba3_q <= ub_av;
  end

  // Stage 4: 17x17 partial products of each radicand.
  logic [2*HW-1:0] pp_q [8];

  always_ff @(posedge clk_i) begin
    side4_q <= side3_q;
    pp_q[0] <= ua3_q[SW-1:HW] * ub3_q[SW-1:HW];
    pp_q[1] <= ua3_q[SW-1:HW] * ub3_q[HW-1:0];
    pp_q[2] <= ua3_q[HW-1:0] * ub3_q[SW-1:HW];
    pp_q[3] <= ua3_q[HW-1:0] * ub3_q[HW-1:0];
    pp_q[4] <= uaa3_q[SW-1:HW] * uba3_q[SW-1:HW];
    pp_q[5] <= uaa3_q[SW-1:HW] * uba3_q[HW-1:0];
    pp_q[6] <= uaa3_q[HW-1:0] * uba3_q[SW-1:HW];
    pp_q[7] <= uaa3_q[HW-1:0] * uba3_q[HW-1:0];
  end

  // Stage 5: sum the partial products.
  logic [tbdk_pkg::RAD_W-1:0] rad5_q, rada5_q;

  always_ff @(posedge clk_i) begin
    side5_q <= side4_q;
    rad5_q  <= (tbdk_pkg::RAD_W'(pp_q[0]) << (2 * HW))
             + (tbdk_pkg::RAD_W'(pp_q[1]) << HW)
             + (tbdk_pkg::RAD_W'(pp_q[2]) << HW)
             + tbdk_pkg::RAD_W'(pp_q[3]);
    rada5_q <= (tbdk_pkg::RAD_W'(pp_q[4]) << (2 * HW))
             + (tbdk_pkg::RAD_W'(pp_q[5]) << HW)
             + (tbdk_pkg::RAD_W'(pp_q[6]) << HW)
             + tbdk_pkg::RAD_W'(pp_q[7]);
  end

  always_comb begin
    side_o       = side5_q;
    side_o.valid = v5_q;
  end
  assign rad_o    = rad5_q;
  assign rad_av_o = rada5_q;

endmodule

// ===== rtl/tbdk_sqrt.sv =====
// ----------------------------------------------------------------------------
// tbdk_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tbdk_sqrt (
  input  logic                         clk_i,
  input  logic [tbdk_pkg::RAD_W-1:0]   rad_i,
  output logic [tbdk_pkg::SQ_W-1:0]    root_o
);

  localparam int N  = tbdk_pkg::SQRT_LAT;
  localparam int RW = tbdk_pkg::REM_W;
  localparam int QW = tbdk_pkg::SQ_W;
  localparam int DW = tbdk_pkg::RAD_W;

  logic [RW-1:0] rem_q  [N];
  logic [QW-1:0] root_q [N];
  logic [DW-1:0] rad_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] root_in;
    logic [DW-1:0] rad_in;
    logic [RW+1:0] cur, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign cur   = {rem_in, rad_in[DW-1:DW-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RW'(cur - trial) : RW'(cur);
      root_q[k] <= {root_in[QW-2:0], ge};
      rad_q[k]  <= rad_in << 2;
    end
  end

  assign root_o = root_q[N-1];

endmodule

// ===== rtl/tbdk_div.sv =====
// ----------------------------------------------------------------------------
// tbdk_div
// Pipelined restoring divider with a 16-bit saturating quotient, one
// quotient bit per register stage after a range check.
// ----------------------------------------------------------------------------
module tbdk_div (
  input  logic                          clk_i,
  input  logic [tbdk_pkg::NUM_W-1:0]    num_i,
  input  logic [tbdk_pkg::DVS_W-1:0]    dvs_i,
  output logic [tbdk_pkg::MASS_W-1:0]   quo_o
);

  localparam int QW = tbdk_pkg::MASS_W;
  localparam int DV = tbdk_pkg::DVS_W;
  localparam int NW = tbdk_pkg::NUM_W;

  // Range check: the quotient overflows when the upper part reaches 2W.
  logic          sat_q [QW+1];
  logic [DV-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DV-1:0] dvs_q [QW+1];

  always_ff @(posedge clk_i) begin
    sat_q[0] <= num_i[NW-1:QW] >= (NW-QW)'(dvs_i);
    rem_q[0] <= DV'(num_i[NW-1:QW]);
    low_q[0] <= num_i[QW-1:0];
    quo_q[0] <= '0;
    dvs_q[0] <= dvs_i;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DV:0] t;
    logic        ge;

    assign t  = {rem_q[k-1], low_q[k-1][QW-1]};
    assign ge = t >= {1'b0, dvs_q[k-1]};

    always_ff @(posedge clk_i) begin
      sat_q[k] <= sat_q[k-1];
      rem_q[k] <= ge ? DV'(t - {1'b0, dvs_q[k-1]}) : DV'(t);
      low_q[k] <= low_q[k-1] << 1;
      quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
      dvs_q[k] <= dvs_q[k-1];
    end
  end

  assign quo_o = sat_q[QW] ? '1 : quo_q[QW];

endmodule

// ===== rtl/two_body_decay_kinematics.sv =====
// ----------------------------------------------------------------------------
// two_body_decay_kinematics
// Nucleon and pion energies and momenta of a two-body decay W -> N pi.
// ----------------------------------------------------------------------------
// Usage: raise start with invariant_mass_i, the nucleon and pion choices
// and the direction components; the request is taken at any edge where
// busy is low, and busy stays low, so one request can enter every cycle.
// Each request gives exactly one result, shown for one cycle with valid_o
// high, after it has passed 5 front stages, 34 square root stages,
// 17 divider stages, a multiply stage and the output register.
// Throughput is one request per cycle; results leave in request order.
// The receiver cannot stall, so no result ever waits.
// Mass registers are written through cfg_valid_i/cfg_ready_o with a
// register index and 16-bit data; ready is always high and indexes beyond
// the last register are dropped. Write only while no request is in flight.
// Reset clears the valid pipeline and loads the default masses.
// ----------------------------------------------------------------------------
`include "two_body_decay_kinematics_defines.svh"

module two_body_decay_kinematics (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tbdk_pkg::MASS_W-1:0]          invariant_mass_i,
  input  logic                                 is_neutron_i,
  input  logic                                 is_neutral_pion_i,
  input  logic signed [tbdk_pkg::DIR_W-1:0]    dir_x_i,
  input  logic signed [tbdk_pkg::DIR_W-1:0]    dir_y_i,
  input  logic signed [tbdk_pkg::DIR_W-1:0]    dir_z_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tbdk_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tbdk_pkg::MASS_W-1:0]          cfg_data_i,
  output logic                                 valid_o,
  output logic [tbdk_pkg::MASS_W-1:0]          nucleon_energy_o,
  output logic [tbdk_pkg::MASS_W-1:0]          pion_energy_o,
  output logic signed [tbdk_pkg::MOM_W-1:0]    mom_x_o,
  output logic signed [tbdk_pkg::MOM_W-1:0]    mom_y_o,
  output logic signed [tbdk_pkg::MOM_W-1:0]    mom_z_o,
  output logic [tbdk_pkg::MASS_W-1:0]          avg_momentum_o,
  output logic                                 below_threshold_o,
  output logic                                 no_real_root_o
);

  localparam int MW = tbdk_pkg::MASS_W;
  localparam int PW = MW + tbdk_pkg::DIR_W + 1;

  // Configuration registers.
  logic [MW-1:0] cfg_q [tbdk_pkg::NREG];

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tbdk_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i <= tbdk_pkg::REG_MIN_W)) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  tbdk_pkg::mass_t mass;
  assign mass.proton  = cfg_q[tbdk_pkg::REG_PROTON];
  assign mass.neutron = cfg_q[tbdk_pkg::REG_NEUTRON];
  assign mass.cpion   = cfg_q[tbdk_pkg::REG_CPION];
  assign mass.npion   = cfg_q[tbdk_pkg::REG_NPION];
  assign mass.avg_n   = cfg_q[tbdk_pkg::REG_AVG_N];
  assign mass.avg_pi  = cfg_q[tbdk_pkg::REG_AVG_PI];
  assign mass.min_w   = cfg_q[tbdk_pkg::REG_MIN_W];

  // Front end: squares, Kallen factors and radicands.
  tbdk_pkg::side_t            side_f;
  logic [tbdk_pkg::RAD_W-1:0] rad, rad_av;

  tbdk_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (start && !busy),
    .mass_i            (mass),
    .invariant_mass_i  (invariant_mass_i),
    .is_neutron_i      (is_neutron_i),
    .is_neutral_pion_i (is_neutral_pion_i),
    .dir_x_i           (dir_x_i),
    .dir_y_i           (dir_y_i),
    .dir_z_i           (dir_z_i),
    .side_o            (side_f),
    .rad_o             (rad),
    .rad_av_o          (rad_av)
  );

  // Square roots of both radicands.
  logic [tbdk_pkg::SQ_W-1:0] root, root_av;

  tbdk_sqrt u_sqrt (.clk_i(clk_i), .rad_i(rad),    .root_o(root));
  tbdk_sqrt u_sqrt_av (.clk_i(clk_i), .rad_i(rad_av), .root_o(root_av));

  // Side line beside the square roots; the valid bits run in their own vector.
  logic [tbdk_pkg::SQRT_LAT-1:0] sq_vld_q;
  tbdk_pkg::side_t               sq_side_q [tbdk_pkg::SQRT_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else begin
      sq_vld_q <= {sq_vld_q[tbdk_pkg::SQRT_LAT-2:0], side_f.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    sq_side_q[0] <= side_f;
    for (int i = 1; i < tbdk_pkg::SQRT_LAT; i++) begin
      sq_side_q[i] <= sq_side_q[i-1];
    end
  end

  tbdk_pkg::side_t sq_side;
  always_comb begin
    sq_side       = sq_side_q[tbdk_pkg::SQRT_LAT-1];
    sq_side.valid = sq_vld_q[tbdk_pkg::SQRT_LAT-1];
  end

  // Four dividers by 2W: both energies and both momentum magnitudes.
  logic [MW-1:0] en_q, ep_q, p_q, pav_q;

  tbdk_div u_div_en  (.clk_i(clk_i), .num_i(sq_side.en_num), .dvs_i(sq_side.dvs),
                      .quo_o(en_q));
  tbdk_div u_div_ep  (.clk_i(clk_i), .num_i(sq_side.ep_num), .dvs_i(sq_side.dvs),
                      .quo_o(ep_q));
  tbdk_div u_div_p   (.clk_i(clk_i), .num_i(root),    .dvs_i(sq_side.dvs),
                      .quo_o(p_q));
  tbdk_div u_div_pav (.clk_i(clk_i), .num_i(root_av), .dvs_i(sq_side.dvs),
                      .quo_o(pav_q));

  // Side line beside the dividers; the valid bits run in their own vector.
  logic [tbdk_pkg::DIV_LAT-1:0] dv_vld_q;
  tbdk_pkg::side_t              dv_side_q [tbdk_pkg::DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else begin
      dv_vld_q <= {dv_vld_q[tbdk_pkg::DIV_LAT-2:0], sq_side.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= sq_side;
    for (int i = 1; i < tbdk_pkg::DIV_LAT; i++) begin
      dv_side_q[i] <= dv_side_q[i-1];
    end
  end

  tbdk_pkg::side_t dv_side;
  always_comb begin
    dv_side       = dv_side_q[tbdk_pkg::DIV_LAT-1];
    dv_side.valid = dv_vld_q[tbdk_pkg::DIV_LAT-1];
  end

  // Multiply stage: momentum components; zero W forces every result but the below flag to 0.
  logic [MW-1:0]        p_sel;
  logic                 mul_valid_q;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic [MW-1:0]        en_m_q, ep_m_q, pav_m_q;
  logic                 below_m_q, neg_m_q;

  assign p_sel = dv_side.wzero ? '0 : p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= dv_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q      <= $signed({1'b0, p_sel}) * dv_side.dir_x;
    py_q      <= $signed({1'b0, p_sel}) * dv_side.dir_y;
    pz_q      <= $signed({1'b0, p_sel}) * dv_side.dir_z;
    en_m_q    <= dv_side.wzero ? '0 : en_q;
    ep_m_q    <= dv_side.wzero ? '0 : ep_q;
    pav_m_q   <= dv_side.wzero ? '0 : pav_q;
    below_m_q <= dv_side.below;
    neg_m_q   <= dv_side.neg && !dv_side.wzero;
  end

  // Output stage: floor shift of the fraction bits and clamp.
  localparam int SHW = PW - tbdk_pkg::DIR_FRAC;

  function automatic logic signed [tbdk_pkg::MOM_W-1:0] clamp_mom(
    input logic signed [PW-1:0] prod
  );
    logic signed [SHW-1:0] q;
    logic signed [SHW-1:0] lim;
    q   = SHW'(prod >>> tbdk_pkg::DIR_FRAC);
    lim = $signed(SHW'({MW{1'b1}}));
    if (q > lim) begin
      return tbdk_pkg::MOM_W'(lim);
    end else if (q < -lim) begin
      return tbdk_pkg::MOM_W'(-lim);
    end
    return tbdk_pkg::MOM_W'(q);
  endfunction

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mom_x_o           <= clamp_mom(px_q);
    mom_y_o           <= clamp_mom(py_q);
    mom_z_o           <= clamp_mom(pz_q);
    nucleon_energy_o  <= en_m_q;
    pion_energy_o     <= ep_m_q;
    avg_momentum_o    <= pav_m_q;
    below_threshold_o <= below_m_q;
    no_real_root_o    <= neg_m_q;
  end

  assign valid_o = valid_q;

  // A missing real root must give a zero momentum vector.
  `TBDK_ASSERT_IMP(a_neg_zero_mom, clk_i, rst_ni, valid_o && no_real_root_o,
                   mom_x_o == '0 && mom_y_o == '0 && mom_z_o == '0)
  // Every item in the multiply stage gives a result in the next cycle.
  `TBDK_ASSERT_NXT(a_mul_to_out, clk_i, rst_ni, mul_valid_q, valid_o)
  // Every item on the divider side line enters the multiply stage.
  `TBDK_ASSERT_NXT(a_div_to_mul, clk_i, rst_ni, dv_side.valid, mul_valid_q)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-body decay kinematics testbench
// Sends directed and random decay requests, predicts the energies, the
// momentum vector and the flags with an integer model of its own, and checks
// every result in order. Mass registers are rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = tbdk_pkg::TOTAL_LAT + 20;
  localparam logic [tbdk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [15:0]        en;
    logic [15:0]        ep;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic [15:0]        pav;
    logic               below;
    logic               neg;
  } decay_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] invariant_mass_i = '0;
  logic is_neutron_i = 1'b0;
  logic is_neutral_pion_i = 1'b0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic signed [15:0] dir_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tbdk_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic valid_o;
  logic [15:0] nucleon_energy_o, pion_energy_o, avg_momentum_o;
  logic signed [16:0] mom_x_o, mom_y_o, mom_z_o;
  logic below_threshold_o, no_real_root_o;

  logic [15:0] mass_reg [tbdk_pkg::NREG];
  decay_t      pending_decays [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_gap_pct = 0;

  two_body_decay_kinematics u_dut (.*);

  // Clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Magnitude floor(sqrt(lambda)/(2w)), saturated.
  function automatic logic [15:0] decay_momentum(input longint w, input longint m1,
                                                 input longint m2, output logic neg);
    longint a, b, s, d;
    logic [127:0] rad, root, trial;
    logic [127:0] q;
    s = m1 + m2;
    d = (m1 > m2) ? m1 - m2 : m2 - m1;
    a = w * w - s * s;
    b = w * w - d * d;
    neg = 1'b0;
    if (a < 0 && b > 0) begin
      neg = 1'b1;
      return '0;
    end
    rad = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    root = '0;
    for (int i = 37; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= rad) root = trial;
    end
    q = root / (2 * w);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [15:0] decay_energy(input longint w, input longint m1,
                                               input longint m2);
    longint num;
    num = w * w + m1 * m1 - m2 * m2;
    if (num <= 0) return '0;
    num = num / (2 * w);
    return (num > 65535) ? 16'hFFFF : num[15:0];
  endfunction

  function automatic logic signed [16:0] momentum_component(input longint p,
                                                            input logic signed [15:0] dir);
    longint prod, q;
    prod = p * longint'(dir);
    if (prod >= 0) q = prod >>> tbdk_pkg::DIR_FRAC;
    else q = -((-prod + (64'd1 << tbdk_pkg::DIR_FRAC) - 1) >>> tbdk_pkg::DIR_FRAC);
    if (q > 65535) q = 65535;
    if (q < -65535) q = -65535;
    return q[16:0];
  endfunction

  function automatic decay_t predict_decay(input logic [15:0] w, input logic nb,
                                           input logic pb, input logic signed [15:0] dx,
                                           input logic signed [15:0] dy,
                                           input logic signed [15:0] dz);
    decay_t r;
    longint mn, mp, p;
    logic nav;
    mn = nb ? mass_reg[tbdk_pkg::REG_NEUTRON] : mass_reg[tbdk_pkg::REG_PROTON];
    mp = pb ? mass_reg[tbdk_pkg::REG_NPION] : mass_reg[tbdk_pkg::REG_CPION];
    r = '{default: '0};
    if (w != 0) begin
      r.en = decay_energy(w, mn, mp);
      r.ep = decay_energy(w, mp, mn);
      p = decay_momentum(w, mn, mp, r.neg);
      r.pav = decay_momentum(w, mass_reg[tbdk_pkg::REG_AVG_N],
                             mass_reg[tbdk_pkg::REG_AVG_PI], nav);
      r.px = momentum_component(p, dx);
      r.py = momentum_component(p, dy);
      r.pz = momentum_component(p, dz);
    end
    r.below = (w < mass_reg[tbdk_pkg::REG_MIN_W]);
    return r;
  endfunction

  // Send one request and queue its predicted result.
  task automatic send_decay(input logic [15:0] w, input logic nb, input logic pb,
                            input logic signed [15:0] dx, input logic signed [15:0] dy,
                            input logic signed [15:0] dz);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    invariant_mass_i <= w;
    is_neutron_i <= nb;
    is_neutral_pion_i <= pb;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    do @(posedge clk_i); while (busy);
    pending_decays.push_back(predict_decay(w, nb, pb, dx, dy, dz));
    @(negedge clk_i);
  endtask

  // Wait until every result is in, then let the pipeline settle.
  task automatic drain;
    start <= 1'b0;
    while (pending_decays.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mass(input logic [tbdk_pkg::CFG_IDX_W-1:0] idx,
                            input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < tbdk_pkg::NREG) mass_reg[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] random_dir();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly physical W around the thresholds, some anywhere.
  function automatic logic [15:0] random_mass_w();
    case ($urandom_range(9))
      0: return 16'($urandom_range(255));
      1: return 16'($urandom);
      2: return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom_range(30000, 16000));
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_decay(random_mass_w(), 1'($urandom), 1'($urandom), random_dir(), random_dir(),
                 random_dir());
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    decay_t e;
    if (rst_ni && valid_o) begin
      if (pending_decays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
      end else begin
        e = pending_decays.pop_front();
        if (e.en !== nucleon_energy_o || e.ep !== pion_energy_o || e.px !== mom_x_o ||
            e.py !== mom_y_o || e.pz !== mom_z_o || e.pav !== avg_momentum_o ||
            e.below !== below_threshold_o || e.neg !== no_real_root_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("Mismatch: exp en=%0d ep=%0d p=%0d,%0d,%0d pav=%0d b=%0b n=%0b",
                   e.en, e.ep, e.px, e.py, e.pz, e.pav, e.below, e.neg);
            $display(" got en=%0d ep=%0d p=%0d,%0d,%0d pav=%0d b=%0b n=%0b",
                     nucleon_energy_o, pion_energy_o, mom_x_o, mom_y_o, mom_z_o,
                     avg_momentum_o, below_threshold_o, no_real_root_o);
          end
        end
      end
    end
  end

  // Directed extremes and special cases under reset masses.
  task automatic test_directed;
    send_decay(16'd0, 1'b0, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_decay(16'd1, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    // Below the mass difference: both Kallen factors negative.
    send_decay(16'd12000, 1'b0, 1'b0, 16'sh4000, 16'sh0000, 16'sh0000);
    // Just below the mass difference.
    send_decay(16'd12780, 1'b1, 1'b0, 16'sh0000, 16'sh8000, 16'sh0000);
    // Exact threshold.
    send_decay(16'd17245, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh7FFF);
    send_decay(16'd17279, 1'b1, 1'b1, 16'shC000, 16'sh2000, 16'sh8000);
    send_decay(16'd17280, 1'b0, 1'b1, 16'sh1234, 16'shEDCB, 16'sh5A5A);
    send_decay(16'd20000, 1'b1, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh0001);
    send_decay(16'hFFFF, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF, 16'shFFFF);
    send_decay(16'hFFFF, 1'b1, 1'b1, 16'sh5555, 16'shAAAA, 16'sh0000);
    send_decay(16'h8000, 1'b0, 1'b1, 16'shFFFF, 16'sh0001, 16'sh8000);
    drain();
  endtask

  // Register writes, extreme masses and out-of-range index.
  task automatic test_config_extremes;
    write_mass(tbdk_pkg::REG_PROTON, 16'hFFFF);
    write_mass(tbdk_pkg::REG_NEUTRON, 16'h0000);
    write_mass(tbdk_pkg::REG_CPION, 16'h0000);
    write_mass(tbdk_pkg::REG_NPION, 16'hFFFF);
    write_mass(tbdk_pkg::REG_AVG_N, 16'hFFFF);
    write_mass(tbdk_pkg::REG_AVG_PI, 16'h0000);
    write_mass(tbdk_pkg::REG_MIN_W, 16'hFFFF);
    write_mass(REG_UNUSED, 16'h1234);
    send_decay(16'hFFFF, 1'b0, 1'b0, 16'sh7FFF, 16'sh0000, 16'sh0000);
    send_decay(16'hFFFF, 1'b1, 1'b1, 16'sh8000, 16'sh0000, 16'sh0000);
    // Tiny W with equal nucleon and pion masses.
    send_decay(16'd3, 1'b0, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_decay(16'd1, 1'b1, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_random(40);
    drain();
    write_mass(tbdk_pkg::REG_PROTON, 16'd0);
    write_mass(tbdk_pkg::REG_NPION, 16'd0);
    write_mass(tbdk_pkg::REG_AVG_N, 16'd0);
    write_mass(tbdk_pkg::REG_MIN_W, 16'd0);
    send_random(40);
    drain();
  endtask

  // Random traffic under a mass setting in which each register is random or nominal.
  task automatic test_random_phase(input int count, input int gap_pct);
    send_gap_pct = gap_pct;
    for (int r = 0; r < tbdk_pkg::NREG; r++)
      write_mass(r[tbdk_pkg::CFG_IDX_W-1:0],
                 ($urandom_range(3) == 0) ? 16'($urandom) : tbdk_pkg::CFG_RESET[r]);
    send_random(count);
    // Sender waits for every result before going on.
    drain();
    send_random(count / 4);
    drain();
  endtask

  initial begin
    for (int r = 0; r < tbdk_pkg::NREG; r++) mass_reg[r] = tbdk_pkg::CFG_RESET[r];
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_phase(400, 36);
    test_random_phase(400, 79);
    test_random_phase(400, 0);
    if (mismatches == 0 && pending_decays.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tbdk_pkg.sv
rtl/tbdk_front.sv
rtl/tbdk_sqrt.sv
rtl/tbdk_div.sv
rtl/two_body_decay_kinematics.sv
bench/testbench.sv
